// File: rtl/core/number_to_ascii_formatter_unit_defines.svh
// ----------------------------------------------------------------------------
// Number-to-ASCII formatter assertion macros
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define NUMBER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define N2A_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define N2A_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/n2a_pkg.sv
// ----------------------------------------------------------------------------
// n2a_pkg
// Types, character codes and the microcode program of the number formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package n2a_pkg;

    typedef logic [2:0]  opcode_t;
    typedef logic [31:0] value_t;
    typedef logic [3:0]  frac_t;
    typedef logic [6:0]  char_t;
    typedef logic [3:0]  upc_t;

    localparam opcode_t OP_HEX_NIB    = 3'd0;
    localparam opcode_t OP_HEX_BYTE   = 3'd1;
    localparam opcode_t OP_HEX_WORD16 = 3'd2;
    localparam opcode_t OP_HEX_WORD32 = 3'd3;
    localparam opcode_t OP_UDEC       = 3'd4;
    localparam opcode_t OP_SDEC       = 3'd5;

    localparam frac_t MAX_FRAC = 4'd9;
    localparam frac_t TOP_EXP  = 4'd9;

    localparam char_t CH_ZERO  = 7'h30;
    localparam char_t CH_A     = 7'h41;
    localparam char_t CH_MINUS = 7'h2D;
    localparam char_t CH_POINT = 7'h2E;

    // Datapath actions of one microcode step.
    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_LOAD,
        ACT_EMIT_MINUS,
        ACT_SCAN,
        ACT_CLAMP,
        ACT_SUB,
        ACT_EMIT_DIGIT,
        ACT_EMIT_POINT,
        ACT_DEC_E,
        ACT_HEX_INIT,
        ACT_HEX_EMIT
    } act_t;

    // Jump conditions; a true condition loads the target, else the counter steps.
    typedef enum logic [3:0] {
        CND_NEXT,
        CND_ALWAYS,
        CND_NO_BEAT,
        CND_OP_HEX,
        CND_OP_BAD,
        CND_NOT_NEG,
        CND_SCAN_MORE,
        CND_V_GE_POW,
        CND_NO_POINT,
        CND_E_ZERO,
        CND_E_NZ
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        logic  emit;
        upc_t  target;
    } ucode_word_t;

    typedef struct packed {
        act_t act;
        logic fire;
    } n2a_ctrl_t;

    typedef struct packed {
        logic  op_hex;
        logic  op_bad;
        logic  not_neg;
        logic  scan_more;
        logic  v_ge_pow;
        logic  no_point;
        logic  e_zero;
        char_t emit_char;
        logic  emit_last;
    } n2a_status_t;

    localparam upc_t UA_IDLE      = 4'd0;
    localparam upc_t UA_DEC       = 4'd5;
    localparam upc_t UA_SCAN      = 4'd5;
    localparam upc_t UA_SUB       = 4'd7;
    localparam upc_t UA_DIGIT_END = 4'd11;
    localparam upc_t UA_HEX       = 4'd13;
    localparam upc_t UA_HEX_EMIT  = 4'd14;

    function automatic ucode_word_t ucode_rom(input upc_t addr);
        ucode_word_t w;
        w = '{act: ACT_NOP, cond: CND_NEXT, emit: 1'b0, target: UA_IDLE};
        case (addr)
            4'd0:  w = '{act: ACT_LOAD,       cond: CND_NO_BEAT,   emit: 1'b0,
                         target: UA_IDLE};
            4'd1:  w = '{act: ACT_NOP,        cond: CND_OP_HEX,    emit: 1'b0,
                         target: UA_HEX};
            4'd2:  w = '{act: ACT_NOP,        cond: CND_OP_BAD,    emit: 1'b0,
                         target: UA_IDLE};
            4'd3:  w = '{act: ACT_NOP,        cond: CND_NOT_NEG,   emit: 1'b0,
                         target: UA_DEC};
            4'd4:  w = '{act: ACT_EMIT_MINUS, cond: CND_NEXT,      emit: 1'b1,
                         target: UA_IDLE};
            4'd5:  w = '{act: ACT_SCAN,       cond: CND_SCAN_MORE, emit: 1'b0,
                         target: UA_SCAN};
            4'd6:  w = '{act: ACT_CLAMP,      cond: CND_NEXT,      emit: 1'b0,
                         target: UA_IDLE};
            4'd7:  w = '{act: ACT_SUB,        cond: CND_V_GE_POW,  emit: 1'b0,
                         target: UA_SUB};
            4'd8:  w = '{act: ACT_EMIT_DIGIT, cond: CND_NEXT,      emit: 1'b1,
                         target: UA_IDLE};
            4'd9:  w = '{act: ACT_NOP,        cond: CND_NO_POINT,  emit: 1'b0,
                         target: UA_DIGIT_END};
            4'd10: w = '{act: ACT_EMIT_POINT, cond: CND_NEXT,      emit: 1'b1,
                         target: UA_IDLE};
            4'd11: w = '{act: ACT_NOP,        cond: CND_E_ZERO,    emit: 1'b0,
                         target: UA_IDLE};
            4'd12: w = '{act: ACT_DEC_E,      cond: CND_ALWAYS,    emit: 1'b0,
                         target: UA_SUB};
            4'd13: w = '{act: ACT_HEX_INIT,   cond: CND_NEXT,      emit: 1'b0,
                         target: UA_IDLE};
            4'd14: w = '{act: ACT_HEX_EMIT,   cond: CND_E_NZ,      emit: 1'b1,
                         target: UA_HEX_EMIT};
            4'd15: w = '{act: ACT_NOP,        cond: CND_ALWAYS,    emit: 1'b0,
                         target: UA_IDLE};
            default: w = '{act: ACT_NOP, cond: CND_ALWAYS, emit: 1'b0,
                           target: UA_IDLE};
        endcase
        return w;
    endfunction

    function automatic value_t pow10(input logic [3:0] e);
        value_t p;
        case (e)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

    function automatic char_t hex_char(input logic [3:0] nib);
        char_t c;
        if (nib < 4'd10)
        begin
            c = CH_ZERO + {3'b000, nib};
        end
        else
        begin
            c = CH_A - 7'd10 + {3'b000, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/n2a_datapath.sv
// ----------------------------------------------------------------------------
// n2a_datapath
// Working registers of the formatter, driven one action per microcode step.
// ----------------------------------------------------------------------------
`default_nettype none

module n2a_datapath (
    input  wire                   clk,
    input  n2a_pkg::opcode_t      in_opcode,
    input  n2a_pkg::value_t       in_value,
    input  n2a_pkg::frac_t        in_frac_digits,
    input  n2a_pkg::n2a_ctrl_t    ctrl,
    output n2a_pkg::n2a_status_t  status
);
    import n2a_pkg::*;

    opcode_t    op_reg, op_next;
    value_t     v_reg, v_next;
    logic [3:0] e_reg, e_next;
    frac_t      fp_reg, fp_next;
    logic [3:0] cnt_reg, cnt_next;

    value_t     pow_cur;
    logic       v_ge;

    assign pow_cur = pow10(e_reg);
    assign v_ge    = (v_reg >= pow_cur);

    always_comb
    begin
        op_next  = op_reg;
        v_next   = v_reg;
        e_next   = e_reg;
        fp_next  = fp_reg;
        cnt_next = cnt_reg;
        if (ctrl.fire)
        begin
            case (ctrl.act)
                ACT_LOAD:
                begin
                    op_next  = in_opcode;
                    v_next   = in_value;
                    e_next   = TOP_EXP;
                    fp_next  = (in_frac_digits > MAX_FRAC) ? MAX_FRAC : in_frac_digits;
                    cnt_next = 4'd0;
                end
                ACT_EMIT_MINUS: v_next = 32'd0 - v_reg;
                ACT_SCAN:
                begin
                    if ((e_reg != 4'd0) && !v_ge)
                    begin
                        e_next = e_reg - 4'd1;
                    end
                end
                ACT_CLAMP:
                begin
                    if (e_reg < fp_reg)
                    begin
                        e_next = fp_reg;
                    end
                end
                ACT_SUB:
                begin
                    if (v_ge)
                    begin
                        v_next   = v_reg - pow_cur;
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                ACT_EMIT_DIGIT: cnt_next = 4'd0;
                ACT_DEC_E:      e_next = e_reg - 4'd1;
                ACT_HEX_INIT:
                begin
                    case (op_reg)
                        OP_HEX_NIB:    e_next = 4'd0;
                        OP_HEX_BYTE:   e_next = 4'd1;
                        OP_HEX_WORD16: e_next = 4'd3;
                        default:       e_next = 4'd7;
                    endcase
                end
                ACT_HEX_EMIT:   e_next = e_reg - 4'd1;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        v_reg   <= v_next;
        e_reg   <= e_next;
        fp_reg  <= fp_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        status.op_hex    = (op_reg <= OP_HEX_WORD32);
        status.op_bad    = (op_reg > OP_SDEC);
        status.not_neg   = !((op_reg == OP_SDEC) && v_reg[31]);
        status.scan_more = (e_reg != 4'd0) && !v_ge;
        status.v_ge_pow  = v_ge;
        status.no_point  = (fp_reg == 4'd0) || (e_reg != fp_reg);
        status.e_zero    = (e_reg == 4'd0);
        status.emit_last = 1'b0;
        case (ctrl.act)
            ACT_EMIT_MINUS: status.emit_char = CH_MINUS;
            ACT_EMIT_POINT: status.emit_char = CH_POINT;
            ACT_EMIT_DIGIT:
            begin
                status.emit_char = CH_ZERO + {3'b000, cnt_reg};
                status.emit_last = (e_reg == 4'd0);
            end
            ACT_HEX_EMIT:
            begin
                status.emit_char = hex_char(v_reg[{e_reg[2:0], 2'b00} +: 4]);
                status.emit_last = (e_reg == 4'd0);
            end
            default:        status.emit_char = CH_ZERO;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/number_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_unit
// Formats one 32-bit number as hex or decimal ASCII characters.
// ----------------------------------------------------------------------------
//
// Channel   Dir   Beat carries
// s_*       in    one number: opcode, value, frac_digits
// m_*       out   one ASCII character; tlast on the final character
//
// A microcoded sequencer of sixteen steps drives the datapath and takes a new
// number only in its idle step, after it has emitted the last character of the
// one before. Decimal digits come from a repeated-subtraction loop.
// Reset is asynchronous and puts the step counter in its idle step with no
// character pending. A stalled output holds the sequencer on its emit step
// while one finished character waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module number_to_ascii_formatter_unit (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    // [2:0] opcode, [34:3] value, [38:35] frac_digits, [39] zero pad
    input  wire [39:0] s_tdata,
    output logic       m_tvalid,
    input  wire        m_tready,
    // [6:0] char_code, [7] zero pad
    output logic [7:0] m_tdata,
    output logic       m_tlast
);
    import n2a_pkg::*;

`include "number_to_ascii_formatter_unit_defines.svh"

    upc_t          upc_reg, upc_next;
    logic          out_valid_reg, out_valid_next;
    char_t         out_char_reg, out_char_next;
    logic          out_last_reg, out_last_next;

    ucode_word_t   uw;
    n2a_ctrl_t     ctrl;
    n2a_status_t   status;
    logic          in_beat;
    logic          stall;
    logic          cond_true;

    // The current control word comes straight out of the microcode table.
    assign uw = ucode_rom(upc_reg);

    assign s_tready = (upc_reg == UA_IDLE);
    assign in_beat  = s_tvalid && s_tready;

    // An emitting step waits until the output register can take a character.
    assign stall = uw.emit && out_valid_reg && !m_tready;

    always_comb
    begin
        ctrl.act  = uw.act;
        ctrl.fire = !stall && ((upc_reg != UA_IDLE) || in_beat);
    end

    n2a_datapath u_datapath (
        .clk            (clk),
        .in_opcode      (s_tdata[2:0]),
        .in_value       (s_tdata[34:3]),
        .in_frac_digits (s_tdata[38:35]),
        .ctrl           (ctrl),
        .status         (status)
    );

    // Branch condition selected by the control word.
    always_comb
    begin
        case (uw.cond)
            CND_NEXT:      cond_true = 1'b0;
            CND_ALWAYS:    cond_true = 1'b1;
            CND_NO_BEAT:   cond_true = !in_beat;
            CND_OP_HEX:    cond_true = status.op_hex;
            CND_OP_BAD:    cond_true = status.op_bad;
            CND_NOT_NEG:   cond_true = status.not_neg;
            CND_SCAN_MORE: cond_true = status.scan_more;
            CND_V_GE_POW:  cond_true = status.v_ge_pow;
            CND_NO_POINT:  cond_true = status.no_point;
            CND_E_ZERO:    cond_true = status.e_zero;
            CND_E_NZ:      cond_true = !status.e_zero;
            default:       cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        upc_next       = upc_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (!stall)
        begin
            upc_next = cond_true ? uw.target : upc_reg + 4'd1;
            if (uw.emit)
            begin
                out_valid_next = 1'b1;
                out_char_next  = status.emit_char;
                out_last_next  = status.emit_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UA_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

    // The final character of a number is always a digit or a hex letter.
    `N2A_ASSERT_NOW(a_last_is_digit, m_tvalid && m_tlast,
        (m_tdata[6:0] != CH_MINUS) && (m_tdata[6:0] != CH_POINT),
        "last character is a sign or point")
    // The sequencer leaves its idle step only on an input beat.
    `N2A_ASSERT_NEXT(a_idle_holds, s_tready && !s_tvalid, s_tready,
        "left idle without an input beat")
    // The sequencer is busy in the cycle after an input beat.
    `N2A_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready,
        "idle right after an input beat")
    // A stalled emit step must not advance the step counter.
    `N2A_ASSERT_NEXT(a_stall_holds_upc, stall, $stable(upc_reg),
        "step counter moved during a stall")

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - number_to_ascii_formatter_unit testbench
// Sends numbers in every hex and decimal format and checks each ASCII
// character beat, and its end-of-number flag, against an in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none

import n2a_pkg::*;

// One expected character beat on the output stream.
typedef struct packed {
    char_t code;
    logic  is_last;
} char_beat_t;

// Predicts the characters of every accepted number and checks the beats
// that leave the block in order against them.
class char_ledger;
    char_beat_t due_chars[$];
    int         mismatches;
    int         chars_seen;

    function new();
        mismatches = 0;
        chars_seen = 0;
    endfunction

    function value_t ten_to(input int e);
        value_t p;
        p = 32'd1;
        repeat (e) p = p * 32'd10;
        return p;
    endfunction

    function void add_char(input char_t c);
        char_beat_t b;
        b.code    = c;
        b.is_last = 1'b0;
        due_chars.push_back(b);
    endfunction

    // Called once per accepted input beat.
    function void note_number(input opcode_t op, input value_t v, input frac_t fd);
        int         ndig;
        int         i;
        int         e;
        int         fp;
        logic [3:0] nib;
        value_t     mag;
        value_t     p;
        value_t     d;
        char_beat_t tail;
        if (op <= OP_HEX_WORD32)
        begin
            ndig = 1 << op;
            for (i = ndig - 1; i >= 0; i--)
            begin
                nib = v[i * 4 +: 4];
                if (nib < 4'd10)
                    add_char(CH_ZERO + {3'b000, nib});
                else
                    add_char(CH_A + {3'b000, nib} - 7'd10);
            end
        end
        else if (op == OP_UDEC || op == OP_SDEC)
        begin
            // Fraction counts above nine behave as nine.
            fp  = (fd > MAX_FRAC) ? int'(MAX_FRAC) : int'(fd);
            mag = v;
            if (op == OP_SDEC && v[31])
            begin
                add_char(CH_MINUS);
                mag = -v;
            end
            // Find the leading power, then pad down so the point has a digit
            // in front of it.
            e = 9;
            while (e > 0 && mag < ten_to(e))
                e--;
            if (e < fp)
                e = fp;
            forever
            begin
                p   = ten_to(e);
                d   = mag / p;
                mag = mag - d * p;
                add_char(CH_ZERO + d[6:0]);
                if (fp != 0 && e == fp)
                    add_char(CH_POINT);
                if (e == 0)
                    break;
                e--;
            end
        end
        else
        begin
            // Unused opcodes produce nothing.
            return;
        end
        tail         = due_chars.pop_back();
        tail.is_last = 1'b1;
        due_chars.push_back(tail);
    endfunction

    function void check_char(input char_t code, input logic is_last);
        char_beat_t want;
        chars_seen++;
        if (due_chars.size() == 0)
        begin
            $display("%0t: unexpected char beat code=%h last=%b",
                     $time, code, is_last);
            mismatches++;
            return;
        end
        want = due_chars.pop_front();
        if (code !== want.code)
        begin
            $display("%0t: char_code mismatch expected=%h actual=%h",
                     $time, want.code, code);
            mismatches++;
        end
        if (is_last !== want.is_last)
        begin
            $display("%0t: last mismatch expected=%b actual=%b",
                     $time, want.is_last, is_last);
            mismatches++;
        end
    endfunction
endclass

module tb;

    // Opcodes the block has no format for; it must drop them silently.
    localparam opcode_t OP_UNUSED_6 = 3'd6;
    localparam opcode_t OP_UNUSED_7 = 3'd7;

    // Cycles with no beat on either side before the run is declared hung.
    // The longest quiet stretch in a correct run is the receiver hold-off
    // below plus one slow decimal number, well under this.
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_CHAR = 400;
    localparam int RANDOM_ITEMS = 150;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    char_ledger ledger = new();
    int         quiet_cycles = 0;
    bit         hold_done = 1'b0;

    number_to_ascii_formatter_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Offers one number and returns at the edge where it is taken. The valid
    // stays high, so a following call keeps the stream back to back.
    task automatic push_number(input opcode_t op, input value_t v, input frac_t fd);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, fd, v, op};
        do
            @(posedge clk);
        while (!s_tready);
        ledger.note_number(op, v, fd);
    endtask

    // Drops valid and waits until every predicted character has come out.
    // The task always waits for a clock edge, so valid is never lowered and
    // raised in the same step.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (ledger.due_chars.size() != 0);
    endtask

    // Picks one random number. Values lean toward the places where decimal
    // formatting changes shape: small numbers, powers of ten and their
    // neighbors, small negatives and the extremes.
    task automatic push_random(inout int counted);
        opcode_t op;
        value_t  v;
        frac_t   fd;
        int      pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_7 : OP_UNUSED_6;
        else if (pick < 45)
            op = opcode_t'($urandom_range(OP_HEX_NIB, OP_HEX_WORD32));
        else
            op = ($urandom_range(0, 1) != 0) ? OP_SDEC : OP_UDEC;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 999);
            2: v = ledger.ten_to($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
            3: v = -$urandom_range(1, 5000);
            4: v = -ledger.ten_to($urandom_range(0, 9));
            default:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h0000_0000;
                    1: v = 32'h8000_0000;
                    2: v = 32'h7FFF_FFFF;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        fd = ($urandom_range(0, 2) == 0) ? frac_t'(0) : frac_t'($urandom_range(0, 15));
        push_number(op, v, fd);
        if (op != OP_UNUSED_6 && op != OP_UNUSED_7)
            counted++;
    endtask

    // Output monitor: every character beat goes to the ledger.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            ledger.check_char(m_tdata[6:0], m_tlast);
    end

    // Watchdog: the run is hung if neither side moves a beat for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver. It switches between always ready, random stalls and a fixed
    // duty pattern, in stretches of random length. Once, after enough
    // characters have passed, it holds off for a long stretch so that the
    // output register fills and the block stops taking numbers.
    initial
    begin
        int mode;
        int span;
        int tick;
        mode = 0;
        span = 50;
        tick = 0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (!hold_done && ledger.chars_seen >= HOLD_AT_CHAR)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 9) < 6);
                    default: m_tready <= ((tick % 7) < 4);
                endcase
                span--;
                if (span <= 0)
                begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(30, 200);
                end
                @(posedge clk);
                tick++;
            end
        end
    end

    // Sender: reset, a directed pass over the corner cases, then random
    // numbers in bursts with random gaps.
    initial
    begin
        int counted;
        int burst;
        int gap;
        int j;
        bit paused;
        counted = 0;
        paused  = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hex formats take the low bits only and ignore the fraction count.
        push_number(OP_HEX_NIB,    32'h0000_000F, 4'd5);
        push_number(OP_HEX_NIB,    32'hFFFF_FFF0, 4'd0);
        push_number(OP_HEX_BYTE,   32'h0000_00A5, 4'd0);
        push_number(OP_HEX_WORD16, 32'h1234_9ABC, 4'd9);
        push_number(OP_HEX_WORD32, 32'hFEDC_BA98, 4'd15);
        push_number(OP_HEX_WORD32, 32'h0123_4567, 4'd0);
        // Unsigned decimal: zero, the largest value, padded fractions and a
        // fraction count that saturates.
        push_number(OP_UDEC, 32'd0,          4'd0);
        push_number(OP_UDEC, 32'hFFFF_FFFF,  4'd0);
        push_number(OP_UDEC, 32'hFFFF_FFFF,  4'd9);
        push_number(OP_UDEC, 32'd12,         4'd3);
        push_number(OP_UDEC, 32'd7,          4'd15);
        push_number(OP_UDEC, 32'd1000000000, 4'd0);
        push_number(OP_UDEC, 32'd999999999,  4'd1);
        push_number(OP_UDEC, 32'd0,          4'd4);
        // Signed decimal: most negative, minus one, most positive and the
        // longest answer of sign, ten digits and a point.
        push_number(OP_SDEC, 32'h8000_0000,  4'd0);
        push_number(OP_SDEC, 32'hFFFF_FFFF,  4'd0);
        push_number(OP_SDEC, 32'h7FFF_FFFF,  4'd0);
        push_number(OP_SDEC, -32'sd12,       4'd9);
        push_number(OP_SDEC, 32'h8000_0000,  4'd9);
        push_number(OP_SDEC, 32'd5,          4'd2);
        // Unused opcodes, each followed by a real number to show nothing
        // stray slipped out between them.
        push_number(OP_UNUSED_6, 32'hFFFF_FFFF, 4'd15);
        push_number(OP_UDEC,     32'd42,        4'd0);
        push_number(OP_UNUSED_7, 32'h1234_5678, 4'd1);
        push_number(OP_HEX_BYTE, 32'h0000_003C, 4'd0);

        // The sender sits idle until the block has emptied completely.
        wait_drained();

        while (counted < RANDOM_ITEMS)
        begin
            // Mostly short bursts; now and then a long one with no gaps.
            if ($urandom_range(0, 7) == 0)
                burst = $urandom_range(15, 30);
            else
                burst = $urandom_range(1, 8);
            for (j = 0; j < burst && counted < RANDOM_ITEMS; j++)
                push_random(counted);
            if (!paused && counted >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
            else
            begin
                gap = $urandom_range(0, 6);
                if (gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        wait_drained();
        // Any stray beat after the last number would show up within this.
        repeat (120) @(posedge clk);

        if (ledger.mismatches == 0 && ledger.due_chars.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
